### hw/rtl/adb_message_deframer_defines.svh
// assertion macros shared by the deframer checker
// expects clk in the scope of each use, and rst_n for all but ADB_ASSERT_NEXT_ALWAYS
`ifndef ADB_MESSAGE_DEFRAMER_DEFINES_SVH
`define ADB_MESSAGE_DEFRAMER_DEFINES_SVH

// same-cycle implication, off during reset
`define ADB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, off during reset
`define ADB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, checked through reset as well
`define ADB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### hw/rtl/adb_pkg.sv
// shared types, codes and sizes for the message deframer
// no dependencies
package adb_pkg;

  localparam int MAX_DATA    = 4096;
  localparam int LEFT_W      = $clog2(MAX_DATA + 1);
  localparam int HDR_BYTES   = 24;
  localparam int HDR_W       = 8 * HDR_BYTES;
  localparam int HCNT_W      = 5;
  localparam int CAP_W       = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W  = 3;

  localparam int W_CMD   = 0;
  localparam int W_ARG0  = 1;
  localparam int W_ARG1  = 2;
  localparam int W_LEN   = 3;
  localparam int W_CHECK = 4;
  localparam int W_MAGIC = 5;

  localparam logic [31:0]      MAGIC_MASK      = 32'hffff_ffff;
  localparam logic [31:0]      MAX_DATA_W32    = 32'(MAX_DATA);
  localparam logic [CAP_W-1:0] MAX_PAYLOAD_RST = CAP_W'(4096);

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

  localparam logic [CFG_ADDR_W-3:0] REG_MAX_PAYLOAD = '0;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_FROZEN
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] command_word;
    logic [31:0] first_arg;
    logic [31:0] second_arg;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        message_end;
    logic        check_ok;
  } out_t;

endpackage

### hw/rtl/adb_regs.sv
// apb-style configuration register file for the deframer
// depends on adb_pkg
module adb_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [adb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [adb_pkg::CAP_W-1:0]      max_payload
);

  logic [adb_pkg::CAP_W-1:0]      max_payload_r;
  logic [adb_pkg::CAP_W-1:0]      max_payload_nxt;
  logic [adb_pkg::CFG_ADDR_W-3:0] reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[adb_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    max_payload_nxt = max_payload_r;
    prdata          = '0;
    unique case (reg_idx)
      adb_pkg::REG_MAX_PAYLOAD: begin
        prdata = {{(32 - adb_pkg::CAP_W){1'b0}}, max_payload_r};
        if (wr_en) begin
          max_payload_nxt = pwdata[adb_pkg::CAP_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= adb_pkg::MAX_PAYLOAD_RST;
    end else begin
      max_payload_r <= max_payload_nxt;
    end
  end

  assign max_payload = max_payload_r;

endmodule

### hw/rtl/adb_front.sv
// front end: header assembly, header checks, payload pass-through and sum
// depends on adb_pkg
module adb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  adb_pkg::in_t              in_data,
  input  logic [adb_pkg::CAP_W-1:0] max_payload,
  output logic                      push,
  output adb_pkg::out_t             push_data
);

  adb_pkg::phase_t                phase_r, phase_nxt;
  logic [adb_pkg::HCNT_W-1:0]     hcnt_r, hcnt_nxt;
  logic [adb_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  logic [adb_pkg::LEFT_W-1:0]     left_r, left_nxt;
  logic [31:0]                    sum_r, sum_nxt;

  logic [adb_pkg::HDR_W-1:0] hdr_full;
  logic [31:0]               w_cmd, w_arg0, w_arg1, w_len, w_magic, w_check;
  logic [31:0]               max32, cap32, sum_add;
  logic                      is_byte, hdr_last, bad_magic, too_long, len_zero;
  logic                      pay_last, sum_ok;

  assign hdr_full = {in_data.rx_byte, hdr_r[adb_pkg::HDR_W-1:8]};
  assign w_cmd    = hdr_full[32*adb_pkg::W_CMD   +: 32];
  assign w_arg0   = hdr_full[32*adb_pkg::W_ARG0  +: 32];
  assign w_arg1   = hdr_full[32*adb_pkg::W_ARG1  +: 32];
  assign w_len    = hdr_full[32*adb_pkg::W_LEN   +: 32];
  assign w_magic  = hdr_full[32*adb_pkg::W_MAGIC +: 32];
  assign w_check  = hdr_r[32*adb_pkg::W_CHECK +: 32];

  assign max32     = {{(32 - adb_pkg::CAP_W){1'b0}}, max_payload};
  assign cap32     = (max32 < adb_pkg::MAX_DATA_W32) ? max32 : adb_pkg::MAX_DATA_W32;
  assign is_byte   = accept && (in_data.action == adb_pkg::ACT_BYTE);
  assign hdr_last  = (hcnt_r == adb_pkg::HCNT_W'(adb_pkg::HDR_BYTES - 1));
  assign bad_magic = (w_magic != (w_cmd ^ adb_pkg::MAGIC_MASK));
  assign too_long  = (w_len > cap32);
  assign len_zero  = (w_len == 32'd0);
  assign sum_add   = sum_r + {24'd0, in_data.rx_byte};
  assign pay_last  = (left_r <= adb_pkg::LEFT_W'(1));
  assign sum_ok    = (sum_add == w_check);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    hdr_nxt   = hdr_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    if (accept && (in_data.action == adb_pkg::ACT_RESTART)) begin
      phase_nxt = adb_pkg::PH_HEADER;
      hcnt_nxt  = '0;
      left_nxt  = '0;
      sum_nxt   = '0;
    end else if (is_byte) begin
      unique case (phase_r)
        adb_pkg::PH_HEADER: begin
          hdr_nxt = hdr_full;
          if (hdr_last) begin
            hcnt_nxt = '0;
            sum_nxt  = '0;
            if (bad_magic || too_long) begin
              phase_nxt = adb_pkg::PH_FROZEN;
            end else if (!len_zero) begin
              phase_nxt = adb_pkg::PH_PAYLOAD;
              left_nxt  = w_len[adb_pkg::LEFT_W-1:0];
            end
          end else begin
            hcnt_nxt = hcnt_r + adb_pkg::HCNT_W'(1);
          end
        end
        adb_pkg::PH_PAYLOAD: begin
          if (pay_last) begin
            left_nxt  = '0;
            sum_nxt   = '0;
            phase_nxt = sum_ok ? adb_pkg::PH_HEADER : adb_pkg::PH_FROZEN;
          end else begin
            left_nxt = left_r - adb_pkg::LEFT_W'(1);
            sum_nxt  = sum_add;
          end
        end
        adb_pkg::PH_FROZEN: begin
          phase_nxt = adb_pkg::PH_FROZEN;
        end
        default: begin
          phase_nxt = adb_pkg::PH_FROZEN;
        end
      endcase
    end
  end

  // result generation
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (is_byte) begin
      unique case (phase_r)
        adb_pkg::PH_HEADER: begin
          if (hdr_last) begin
            push                     = 1'b1;
            push_data.command_word   = w_cmd;
            push_data.first_arg      = w_arg0;
            push_data.second_arg     = w_arg1;
            push_data.payload_length = w_len;
            if (bad_magic) begin
              push_data.kind = adb_pkg::KIND_BAD_MAGIC;
            end else if (too_long) begin
              push_data.kind = adb_pkg::KIND_TOO_LONG;
            end else begin
              push_data.kind        = adb_pkg::KIND_HEADER;
              push_data.message_end = len_zero;
              push_data.check_ok    = len_zero;
            end
          end
        end
        adb_pkg::PH_PAYLOAD: begin
          push                   = 1'b1;
          push_data.kind         = adb_pkg::KIND_PAYLOAD;
          push_data.payload_byte = in_data.rx_byte;
          push_data.message_end  = pay_last;
          push_data.check_ok     = pay_last && sum_ok;
        end
        adb_pkg::PH_FROZEN: begin
          push = 1'b0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= adb_pkg::PH_HEADER;
      hcnt_r  <= '0;
      left_r  <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // header bytes shift in; 24 shifts overwrite the whole word set
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

### hw/rtl/adb_queue.sv
// short result queue between front end and output channel
// depends on adb_pkg
module adb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adb_pkg::out_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output adb_pkg::out_t out_data
);

  adb_pkg::out_t              mem_r [adb_pkg::QUEUE_DEPTH];
  logic [adb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [adb_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [adb_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  localparam logic [adb_pkg::QPTR_W-1:0] PTR_LAST = adb_pkg::QPTR_W'(adb_pkg::QUEUE_DEPTH - 1);

  assign full      = (cnt_r == adb_pkg::QCNT_W'(adb_pkg::QUEUE_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + adb_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + adb_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + adb_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - adb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/adb_message_deframer.sv
// deframer top level: config registers, front end and result queue
// depends on adb_pkg, adb_regs, adb_front, adb_queue
// a result is registered into the result queue and offered on out_valid once earlier results are taken
// throughput: one item per cycle; in_ready falls only when the two-entry result queue is full
// items that give no result still stall while the queue is full
// synchronous active-low reset: header phase, counters and queue cleared, max_payload to 4096
module adb_message_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  adb_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output adb_pkg::out_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [adb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [adb_pkg::CAP_W-1:0] max_payload;
  logic                      accept;
  logic                      push;
  logic                      full;
  adb_pkg::out_t             push_data;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  adb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  adb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .max_payload (max_payload),
    .push        (push),
    .push_data   (push_data)
  );

  adb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/adb_checker.sv
// port-level checks on the deframer, attached by bind
// depends on adb_pkg and adb_message_deframer_defines.svh
`include "adb_message_deframer_defines.svh"

module adb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input adb_pkg::out_t out_data
);

  logic is_payload;
  logic is_error;
  logic hdr_zero;

  assign is_payload = out_valid && (out_data.kind == adb_pkg::KIND_PAYLOAD);
  assign is_error   = out_valid && ((out_data.kind == adb_pkg::KIND_BAD_MAGIC) ||
                                    (out_data.kind == adb_pkg::KIND_TOO_LONG));
  assign hdr_zero   = (out_data.command_word == 32'd0) && (out_data.first_arg == 32'd0) &&
                      (out_data.second_arg == 32'd0) && (out_data.payload_length == 32'd0);

  `ADB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ADB_ASSERT_NEXT_ALWAYS(a_ready_after_reset, !rst_n, in_ready)
  `ADB_ASSERT_NOW(a_payload_no_header, is_payload, hdr_zero)
  `ADB_ASSERT_NOW(a_ok_needs_end, out_valid && out_data.check_ok, out_data.message_end)
  `ADB_ASSERT_NOW(a_error_no_end, is_error, !out_data.message_end && (out_data.payload_byte == 8'd0))

endmodule

bind adb_message_deframer adb_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
